// ===== rtl/msnp_pkg.sv =====
// Shared definitions for the MOESIF snooping line controller.
// Field widths, event codes and the packed result record; no dependencies.
`default_nettype none

package msnp_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int ID_BITS    = 4;
  localparam int OP_BITS    = 3;
  localparam int STATE_BITS = 4;

  // Input tdata: addr, requester_id, shared_in, padded to whole bytes.
  localparam int IN_FIELD_BITS = ADDR_BITS + ID_BITS + 1;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_GETS  = 3'd2,
    OP_GETM  = 3'd3,
    OP_DATA  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_GETS = 2'd1,
    CMD_GETM = 2'd2,
    CMD_DATA = 2'd3
  } bus_cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_PENDING = 2'd1,
    ERR_HOLDING = 2'd2,
    ERR_ILLEGAL = 2'd3
  } err_t;

  // First member is the most significant, so bus_cmd lands in the lowest bits.
  typedef struct packed {
    logic [STATE_BITS-1:0] new_state;
    err_t                  error;
    logic                  silent_upgrade;
    logic                  miss;
    logic                  assert_shared;
    logic                  proc_done;
    logic [ID_BITS-1:0]    data_dest;
    logic [ADDR_BITS-1:0]  msg_addr;
    bus_cmd_t              bus_cmd;
  } result_t;

  localparam int RES_BITS      = $bits(result_t);
  localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [ADDR_BITS-1:0] addr;
    logic [ID_BITS-1:0]   requester_id;
    logic                 shared_in;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/msnp_line_fsm.sv =====
// Line state register and transition logic of the MOESIF snooping controller.
// Depends on msnp_pkg for the item and result records and the event codes.
`default_nettype none

module msnp_line_fsm
  import msnp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,   // commit the transition for item
  input  wire item_t   item,
  output result_t      result
);

  typedef enum logic [STATE_BITS-1:0] {
    ST_I  = 4'd0,
    ST_S  = 4'd1,
    ST_E  = 4'd2,
    ST_O  = 4'd3,
    ST_M  = 4'd4,
    ST_F  = 4'd5,
    ST_IS = 4'd6,
    ST_IM = 4'd7,
    ST_SM = 4'd8,
    ST_OM = 4'd9,
    ST_FM = 4'd10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    bus_cmd_t cmd;
    err_t     err;
    logic     done;
    logic     shr;
    logic     mis;
    logic     up;
    logic     getm;

    cmd       = CMD_NONE;
    err       = ERR_NONE;
    done      = 1'b0;
    shr       = 1'b0;
    mis       = 1'b0;
    up        = 1'b0;
    getm      = (item.op == OP_GETM);
    state_nxt = state_r;

    unique case (item.op) inside
      OP_LOAD, OP_STORE: begin
        unique case (state_r) inside
          ST_I: begin
            mis = 1'b1;
            if (item.op == OP_LOAD) begin
              cmd       = CMD_GETS;
              state_nxt = ST_IS;
            end else begin
              cmd       = CMD_GETM;
              state_nxt = ST_IM;
            end
          end
          ST_S, ST_O, ST_F: begin
            if (item.op == OP_LOAD) begin
              done = 1'b1;
            end else begin
              cmd = CMD_GETM;
              mis = 1'b1;
              if (state_r == ST_S)      state_nxt = ST_SM;
              else if (state_r == ST_O) state_nxt = ST_OM;
              else                      state_nxt = ST_FM;
            end
          end
          ST_E: begin
            done = 1'b1;
            if (item.op == OP_STORE) begin
              state_nxt = ST_M;
              up        = 1'b1;
            end
          end
          ST_M: begin
            done = 1'b1;
          end
          ST_IS, ST_IM, ST_SM, ST_OM, ST_FM: begin
            err = ERR_PENDING;
          end
          default: begin
            err = ERR_ILLEGAL;
          end
        endcase
      end
      OP_DATA: begin
        unique case (state_r) inside
          ST_I: begin
          end
          ST_IS: begin
            done      = 1'b1;
            state_nxt = item.shared_in ? ST_S : ST_E;
          end
          ST_IM, ST_SM, ST_OM, ST_FM: begin
            // A pending store completes with ownership, FM included.
            done      = 1'b1;
            state_nxt = ST_M;
          end
          ST_S, ST_E, ST_O, ST_M, ST_F: begin
            err = ERR_HOLDING;
          end
          default: begin
            err = ERR_ILLEGAL;
          end
        endcase
      end
      OP_GETS, OP_GETM: begin
        unique case (state_r) inside
          ST_S, ST_SM: begin
            shr = 1'b1;
            if (getm && state_r == ST_S) state_nxt = ST_I;
          end
          ST_E, ST_O, ST_M, ST_F: begin
            shr = 1'b1;
            cmd = CMD_DATA;
            if (getm)                 state_nxt = ST_I;
            else if (state_r == ST_E) state_nxt = ST_F;
            else if (state_r == ST_M) state_nxt = ST_O;
          end
          ST_OM, ST_FM: begin
            shr = 1'b1;
            cmd = CMD_DATA;
            if (getm) state_nxt = ST_IM;
          end
          ST_I, ST_IS, ST_IM: begin
            // Nothing to supply: the line is invalid or our own request is still in flight.
          end
          default: begin
            err = ERR_ILLEGAL;
          end
        endcase
      end
      default: begin
        err = ERR_ILLEGAL;
      end
    endcase

    if (err != ERR_NONE) begin
      cmd       = CMD_NONE;
      done      = 1'b0;
      shr       = 1'b0;
      mis       = 1'b0;
      up        = 1'b0;
      state_nxt = state_r;
    end

    result.bus_cmd        = cmd;
    result.msg_addr       = (cmd != CMD_NONE || done) ? item.addr : '0;
    result.data_dest      = (cmd == CMD_DATA) ? item.requester_id : '0;
    result.proc_done      = done;
    result.assert_shared  = shr;
    result.miss           = mis;
    result.silent_upgrade = up;
    result.error          = err;
    result.new_state      = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_I;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/moesif_snoop_line_controller.sv =====
// Top level of the MOESIF snooping line controller: stream ports, input and
// result registers around the line state machine. Uses msnp_pkg, msnp_line_fsm.
`default_nettype none

//  Channel | Ports                      | Carries
//  --------+----------------------------+--------------------------------------
//  input   | in_tvalid/tready/tdata/tuser | one event: op in tuser, addr,
//          |                            | requester_id, shared_in in tdata
//  result  | out_tvalid/tready/tdata    | one result per event: bus message,
//          |                            | completion flags, error, new state
//
// An accepted event sits in the input register while the state lookup works on
// it; its result is then captured in the result register, from which it leaves
// on the output channel. The line state is a single register, so one event per
// cycle is sustained while the result channel is not stalled.
// A stalled result register holds the event in the input register; a new
// transaction is still accepted whenever the input register drains that cycle.
// Synchronous active-low reset empties both registers and puts the line in I.

module moesif_snoop_line_controller
  import msnp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // [ADDR_BITS-1:0] addr, then requester_id, then shared_in, zero padding above
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  // op
  input  wire logic [OP_BITS-1:0]       in_tuser,

  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // bus_cmd, msg_addr, data_dest, proc_done, assert_shared, miss,
  // silent_upgrade, error, new_state, zero padding above
  output logic [OUT_DATA_BITS-1:0]      out_tdata
);

  // Input register: holds one accepted event until the lookup consumes it.
  logic    in_vld_r;
  item_t   in_item_r;

  // Result register.
  logic    out_vld_r;
  result_t out_res_r;

  result_t lookup_res;
  logic    advance;

  // The event moves on when the result register is empty or being emptied.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.op           <= in_tuser;
      in_item_r.addr         <= in_tdata[ADDR_BITS-1:0];
      in_item_r.requester_id <= in_tdata[ADDR_BITS +: ID_BITS];
      in_item_r.shared_in    <= in_tdata[ADDR_BITS+ID_BITS];
    end
  end

  msnp_line_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (lookup_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= lookup_res;
    end
  end

  assign out_tvalid = out_vld_r;

  always_comb begin
    out_tdata               = '0;
    out_tdata[RES_BITS-1:0] = out_res_r;
  end

endmodule

`default_nettype wire
